// ----- src/frm_pkg.sv -----
package frm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_FRAME   = 65536;

  localparam int SUM_W   = 63;
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int CNT_W   = $clog2(MAX_FRAME + 1);
  localparam int LEVEL_W = 24;
  localparam int ROOT_W  = (SUM_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } frame_t;

endpackage

// ----- src/frm_front.sv -----
module frm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [frm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                              last_sample_i,
  output logic                              push_o,
  output frm_pkg::frame_t                   frame_o,
  input  logic                              full_i
);

  logic                             v1_q;
  logic                             last1_q;
  logic [frm_pkg::SQ_W-1:0]         sq1_q;
  logic [frm_pkg::SAMPLE_BITS-1:0]  mag;
  logic [frm_pkg::SQ_W-1:0]         sq_d;
  logic                             adv;
  logic                             accept;

  logic [frm_pkg::SUM_W-1:0]        sum_q, sum_d, sum_nxt;
  logic [frm_pkg::CNT_W-1:0]        count_q, count_d, count_nxt;
  logic                             ovf_q, ovf_d, ovf_nxt;
  logic [frm_pkg::SUM_W:0]          sum_add;
  logic                             cnt_full;

  assign adv     = !(v1_q && last1_q && full_i);
  assign stall_o = v1_q && !adv;
  assign accept  = valid_i && !stall_o;

  always_comb begin
    if (sample_i[frm_pkg::SAMPLE_BITS-1]) begin
      mag = ~sample_i + 1'b1;
    end else begin
      mag = sample_i;
    end
    sq_d = mag * mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq1_q   <= sq_d;
      last1_q <= last_sample_i;
    end
  end

  always_comb begin
    cnt_full  = (count_q == frm_pkg::CNT_W'(frm_pkg::MAX_FRAME));
    sum_add   = {1'b0, sum_q} + (frm_pkg::SUM_W + 1)'(sq1_q);
    sum_nxt   = sum_q;
    count_nxt = count_q;
    ovf_nxt   = ovf_q;
    if (cnt_full) begin
      ovf_nxt = 1'b1;
    end else begin
      sum_nxt   = sum_add[frm_pkg::SUM_W] ? frm_pkg::SUM_LIMIT : sum_add[frm_pkg::SUM_W-1:0];
      count_nxt = count_q + 1'b1;
    end

    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    push_o  = 1'b0;
    if (v1_q && adv) begin
      if (last1_q) begin
        push_o  = 1'b1;
        sum_d   = '0;
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        sum_d   = sum_nxt;
        count_d = count_nxt;
        ovf_d   = ovf_nxt;
      end
    end
    frame_o.sum   = sum_nxt;
    frame_o.count = count_nxt;
    frame_o.ovf   = ovf_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ----- src/frm_queue.sv -----
module frm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  frm_pkg::frame_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output frm_pkg::frame_t data_o
);

  frm_pkg::frame_t                mem_q [frm_pkg::QUEUE_DEPTH];
  logic [frm_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [frm_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == frm_pkg::QCNT_W'(frm_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == frm_pkg::QPTR_W'(frm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == frm_pkg::QPTR_W'(frm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + frm_pkg::QCNT_W'(push_i && !full_o) - frm_pkg::QCNT_W'(pop_i && !empty_o);
    end
  end

endmodule

// ----- src/frm_back.sv -----
module frm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  frm_pkg::frame_t               frame_i,
  output logic                          pop_o,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [frm_pkg::LEVEL_W-1:0]   rms_level_o,
  output logic [frm_pkg::CNT_W-1:0]     frame_length_o,
  output logic                          overflow_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [frm_pkg::STEP_W-1:0]   step_q, step_d;
  logic [frm_pkg::SUM_W-1:0]    dvd_q, dvd_d;
  logic [frm_pkg::CNT_W-1:0]    dvs_q, dvs_d;
  logic [frm_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [frm_pkg::RAD_W-1:0]    rad_q, rad_d;
  logic [frm_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [frm_pkg::ROOT_W+1:0]   srem_q, srem_d;
  logic [frm_pkg::CNT_W-1:0]    len_q, len_d;
  logic                         ovf_q, ovf_d;
  logic                         out_v_q, out_v_d;
  logic                         load_out;

  logic [frm_pkg::CNT_W:0]      dtrial;
  logic                         dbit;
  logic [frm_pkg::ROOT_W+3:0]   strial, starget;

  always_comb begin
    dtrial  = {rem_q, dvd_q[frm_pkg::SUM_W-1]};
    dbit    = (dtrial >= {1'b0, dvs_q});
    starget = {srem_q, rad_q[frm_pkg::RAD_W-1 -: 2]};
    strial  = {2'b00, root_q, 2'b01};

    state_d  = state_q;
    step_d   = step_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    rad_d    = rad_q;
    root_d   = root_q;
    srem_d   = srem_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    pop_o    = 1'b0;
    load_out = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          dvd_d   = frame_i.sum;
          dvs_d   = frame_i.count;
          rem_d   = '0;
          len_d   = frame_i.count;
          ovf_d   = frame_i.ovf;
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = dbit ? frm_pkg::CNT_W'(dtrial - {1'b0, dvs_q}) : dtrial[frm_pkg::CNT_W-1:0];
        dvd_d = {dvd_q[frm_pkg::SUM_W-2:0], dbit};
        if (step_q == frm_pkg::STEP_W'(frm_pkg::SUM_W - 1)) begin
          rad_d   = frm_pkg::RAD_W'(dvd_d);
          root_d  = '0;
          srem_d  = '0;
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SQRT: begin
        rad_d = {rad_q[frm_pkg::RAD_W-3:0], 2'b00};
        if (starget >= strial) begin
          srem_d = (frm_pkg::ROOT_W + 2)'(starget - strial);
          root_d = {root_q[frm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = starget[frm_pkg::ROOT_W+1:0];
          root_d = {root_q[frm_pkg::ROOT_W-2:0], 1'b0};
        end
        if (step_q == frm_pkg::STEP_W'(frm_pkg::ROOT_W - 1)) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_v_q || !stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_v_d = 1'b1;
    end else if (!stall_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
    len_q  <= len_d;
    ovf_q  <= ovf_d;
    if (load_out) begin
      rms_level_o    <= root_q[frm_pkg::LEVEL_W-1:0];
      frame_length_o <= len_q;
      overflow_o     <= ovf_q;
    end
  end

  assign valid_o = out_v_q;

endmodule

// ----- src/frame_rms_meter.sv -----
// RMS level meter for framed audio.
//
// Input channel (valid_i / stall_o): one signed sample per transfer, with
// last_sample_i marking the final sample of a frame. Samples are squared and
// summed at one transfer per cycle; stall_o rises only when a frame ends while
// the two-entry frame queue is full.
//
// Output channel (valid_o / stall_i): one transfer per frame carrying
// floor(sqrt(floor(sum / count))), the frame length and the overflow flag.
// Frames beyond MAX_FRAME samples stop accumulating and report overflow.
//
// The latency from the last sample of a frame to valid_o is set by the back
// end: a restoring divider followed by a two-bits-per-step square root. It
// takes one frame at a time and pops the next only after loading a result;
// shorter frames are absorbed by the queue and then back-pressure the input.
//
// Reset clears the running sum, count, queue and output valid. While stall_i
// is high the output holds its result; the back end finishes its current frame
// and waits, and the front keeps accepting until the queue fills.
module frame_rms_meter (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    stall_o,
  input  logic signed [frm_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                    last_sample_i,
  output logic                                    valid_o,
  input  logic                                    stall_i,
  output logic [frm_pkg::LEVEL_W-1:0]             rms_level_o,
  output logic [frm_pkg::CNT_W-1:0]               frame_length_o,
  output logic                                    overflow_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  frm_pkg::frame_t frame_in;
  frm_pkg::frame_t frame_out;

  frm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .push_o        (push),
    .frame_o       (frame_in),
    .full_i        (full)
  );

  frm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (frame_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (frame_out)
  );

  frm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .frame_i        (frame_out),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .rms_level_o    (rms_level_o),
    .frame_length_o (frame_length_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ----- src/frm_checker.sv -----
module frm_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    valid_o,
  input logic                                    stall_i,
  input logic [frm_pkg::LEVEL_W-1:0]             rms_level_o,
  input logic [frm_pkg::CNT_W-1:0]               frame_length_o,
  input logic                                    overflow_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(rms_level_o) && $stable(frame_length_o)
      && $stable(overflow_o))
    else $error("output changed while stalled");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> frame_length_o != '0)
    else $error("empty frame reported");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_o |-> frame_length_o == frm_pkg::CNT_W'(frm_pkg::MAX_FRAME))
    else $error("overflow without full count");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rms_level_o <= frm_pkg::LEVEL_W'(1 << (frm_pkg::SAMPLE_BITS - 1)))
    else $error("level beyond full scale");

endmodule

bind frame_rms_meter frm_checker u_frm_checker (.*);
